// ===== hdl/plq_pkg.sv =====
// ----------------------------------------------------------------------------
// plq_pkg
// Shared types and constants for the pooled linked queue.
// ----------------------------------------------------------------------------
package plq_pkg;

   localparam int POOL_DEPTH = 128;
   localparam int DATA_WIDTH = 32;
   localparam int HANDLE_W   = $clog2(POOL_DEPTH);
   localparam int LINK_W     = HANDLE_W + 1;
   localparam int COUNT_W    = HANDLE_W + 1;

   // null marker for links and pointers
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_WRITE  = 3'd4,
      OP_PEEK   = 3'd5,
      OP_REWIND = 3'd6,
      OP_NEXT   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_END   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_LINK,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [DATA_WIDTH-1:0] value_in;
      logic [HANDLE_W-1:0]   handle_in;
   } req_item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value_out;
      logic [HANDLE_W-1:0]   handle_out;
      logic [COUNT_W-1:0]    occupancy;
      logic [1:0]            status;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // latch request, issue node reads
      logic exec;      // main update step
      logic link;      // second link write
      logic load_rsp;  // move result into output register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_link;
      logic rsp_busy;
   } dp_stat_type;

endpackage

// ===== hdl/plq_ctrl.sv =====
// ----------------------------------------------------------------------------
// plq_ctrl
// Sequencer: accept, update, optional link write, result hand-off.
// ----------------------------------------------------------------------------
module plq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   input  plq_pkg::dp_stat_type  stat,
   output plq_pkg::ctl_cmd_type  cmd
);

   plq_pkg::fsm_state_type state_ff, state_in;
   logic slot_free;

   assign slot_free = !stat.rsp_busy || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plq_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plq_pkg::FSM_IDLE: begin
            if (req_valid) state_in = plq_pkg::FSM_EXEC;
         end
         plq_pkg::FSM_EXEC: begin
            state_in = stat.need_link ? plq_pkg::FSM_LINK : plq_pkg::FSM_DONE;
         end
         plq_pkg::FSM_LINK: begin
            state_in = plq_pkg::FSM_DONE;
         end
         plq_pkg::FSM_DONE: begin
            if (slot_free) state_in = req_valid ? plq_pkg::FSM_EXEC : plq_pkg::FSM_IDLE;
         end
         default: begin
            state_in = plq_pkg::FSM_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.exec     = 1'b0;
      cmd.link     = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         plq_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
         end
         plq_pkg::FSM_EXEC: begin
            cmd.exec = 1'b1;
         end
         plq_pkg::FSM_LINK: begin
            cmd.link = 1'b1;
         end
         plq_pkg::FSM_DONE: begin
            req_ready    = slot_free;
            cmd.load_rsp = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.accept = req_valid && req_ready;
   end

endmodule

// ===== hdl/plq_dpath.sv =====
// ----------------------------------------------------------------------------
// plq_dpath
// Node memories, list pointers, live bits and the output register.
// ----------------------------------------------------------------------------
module plq_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  plq_pkg::ctl_cmd_type  cmd,
   output plq_pkg::dp_stat_type  stat,
   input  plq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plq_pkg::rsp_item_type rsp_item
);

   localparam int DW = plq_pkg::DATA_WIDTH;
   localparam int HW = plq_pkg::HANDLE_W;
   localparam int LW = plq_pkg::LINK_W;
   localparam int CW = plq_pkg::COUNT_W;
   localparam int PD = plq_pkg::POOL_DEPTH;

   // latched request
   plq_pkg::op_type op_ff;
   logic [DW-1:0]   value_ff;
   logic [HW-1:0]   handle_ff;

   // list state
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [LW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] count_ff, count_in;
   plq_pkg::status_type status_ff, status_in;
   logic [PD-1:0] live_ff;
   logic [PD-1:0] next_vld_ff;   // next link written since reset

   // node stores
   logic [DW-1:0] val_mem_ff  [PD];
   logic [LW-1:0] next_mem_ff [PD];
   logic [LW-1:0] prev_mem_ff [PD];

   // read side
   logic [HW-1:0] rd_addr_sel, rd_addr_ff;
   logic [DW-1:0] val_rd_ff;
   logic [LW-1:0] next_raw_ff, prev_rd_ff, next_rd;
   logic          next_vld_rd_ff;
   logic          live_rd_ff;

   // write side
   logic          val_we, next_we, prev_we, live_set, live_clr;
   logic [HW-1:0] val_wa, next_wa, prev_wa;
   logic [DW-1:0] val_wd;
   logic [LW-1:0] next_wd, prev_wd;

   logic          push_fail, empty_fail, unlink_fail, has_value;
   logic          rsp_valid_ff;
   plq_pkg::rsp_item_type rsp_ff;

   // unwritten next links read as index + 1
   assign next_rd = next_vld_rd_ff ? next_raw_ff : (LW'(rd_addr_ff) + LW'(1));

   assign push_fail   = (free_head_ff == plq_pkg::NIL);
   assign empty_fail  = (count_ff == '0) || (head_ff == plq_pkg::NIL);
   assign unlink_fail = (op_ff == plq_pkg::OP_POP) ? empty_fail : !live_rd_ff;

   assign stat.need_link = ((op_ff == plq_pkg::OP_PUSH) && !push_fail) ||
                           (((op_ff == plq_pkg::OP_POP) || (op_ff == plq_pkg::OP_REMOVE))
                            && !unlink_fail);
   assign stat.rsp_busy  = rsp_valid_ff;

   // read address for the incoming request
   always_comb begin
      case (plq_pkg::op_type'(req_item.req_type))
         plq_pkg::OP_PUSH:                  rd_addr_sel = free_head_ff[HW-1:0];
         plq_pkg::OP_POP, plq_pkg::OP_PEEK: rd_addr_sel = head_ff[HW-1:0];
         plq_pkg::OP_NEXT:                  rd_addr_sel = cursor_ff[HW-1:0];
         default:                           rd_addr_sel = req_item.handle_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff          <= plq_pkg::op_type'(req_item.req_type);
         value_ff       <= req_item.value_in;
         handle_ff      <= req_item.handle_in;
         rd_addr_ff     <= rd_addr_sel;
         next_vld_rd_ff <= next_vld_ff[rd_addr_sel];
         live_rd_ff     <= live_ff[rd_addr_sel];
      end
   end

   // update logic
   always_comb begin
      free_head_in = free_head_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      val_we       = 1'b0;
      val_wa       = rd_addr_ff;
      val_wd       = value_ff;
      next_we      = 1'b0;
      next_wa      = rd_addr_ff;
      next_wd      = plq_pkg::NIL;
      prev_we      = 1'b0;
      prev_wa      = rd_addr_ff;
      prev_wd      = tail_ff;
      live_set     = 1'b0;
      live_clr     = 1'b0;
      if (cmd.exec) begin
         status_in = plq_pkg::ST_OK;
         case (op_ff)
            plq_pkg::OP_PUSH: begin
               if (push_fail) begin
                  status_in = plq_pkg::ST_FULL;
               end else begin
                  free_head_in = next_rd;
                  val_we       = 1'b1;
                  next_we      = 1'b1;
                  prev_we      = 1'b1;
                  live_set     = 1'b1;
                  count_in     = count_ff + CW'(1);
               end
            end
            plq_pkg::OP_POP, plq_pkg::OP_REMOVE: begin
               if (unlink_fail) begin
                  status_in = plq_pkg::ST_EMPTY;
               end else begin
                  if (prev_rd_ff != plq_pkg::NIL) begin
                     next_we = 1'b1;
                     next_wa = prev_rd_ff[HW-1:0];
                     next_wd = next_rd;
                  end else begin
                     head_in = next_rd;
                  end
                  if (next_rd != plq_pkg::NIL) begin
                     prev_we = 1'b1;
                     prev_wa = next_rd[HW-1:0];
                     prev_wd = prev_rd_ff;
                  end else begin
                     tail_in = prev_rd_ff;
                  end
                  if (cursor_ff == LW'(rd_addr_ff)) cursor_in = next_rd;
                  live_clr = 1'b1;
                  if (count_ff != '0) count_in = count_ff - CW'(1);
                  if (count_ff <= CW'(1)) begin
                     head_in = plq_pkg::NIL;
                     tail_in = plq_pkg::NIL;
                  end
               end
            end
            plq_pkg::OP_WRITE: begin
               val_we = 1'b1;
            end
            plq_pkg::OP_PEEK: begin
               if (empty_fail) status_in = plq_pkg::ST_EMPTY;
            end
            plq_pkg::OP_REWIND: begin
               cursor_in = head_ff;
            end
            plq_pkg::OP_NEXT: begin
               if (cursor_ff == plq_pkg::NIL) status_in = plq_pkg::ST_END;
               else cursor_in = next_rd;
            end
            default: begin
               status_in = plq_pkg::ST_OK;
            end
         endcase
      end else if (cmd.link) begin
         case (op_ff)
            plq_pkg::OP_PUSH: begin
               if (tail_ff != plq_pkg::NIL) begin
                  next_we = 1'b1;
                  next_wa = tail_ff[HW-1:0];
                  next_wd = LW'(rd_addr_ff);
               end else begin
                  head_in = LW'(rd_addr_ff);
               end
               tail_in = LW'(rd_addr_ff);
            end
            default: begin
               // freed node goes to the front of the free list
               next_we      = 1'b1;
               next_wd      = free_head_ff;
               free_head_in = LW'(rd_addr_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         head_ff      <= plq_pkg::NIL;
         tail_ff      <= plq_pkg::NIL;
         cursor_ff    <= plq_pkg::NIL;
         count_ff     <= '0;
         status_ff    <= plq_pkg::ST_OK;
         live_ff      <= '0;
         next_vld_ff  <= '0;
      end else begin
         free_head_ff <= free_head_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         if (live_set) live_ff[rd_addr_ff] <= 1'b1;
         if (live_clr) live_ff[rd_addr_ff] <= 1'b0;
         if (next_we)  next_vld_ff[next_wa] <= 1'b1;
      end
   end

   // node stores: one write, one registered read each
   always_ff @(posedge clock) begin
      if (val_we) val_mem_ff[val_wa] <= val_wd;
      if (cmd.accept) val_rd_ff <= val_mem_ff[rd_addr_sel];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem_ff[next_wa] <= next_wd;
      if (cmd.accept) next_raw_ff <= next_mem_ff[rd_addr_sel];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem_ff[prev_wa] <= prev_wd;
      if (cmd.accept) prev_rd_ff <= prev_mem_ff[rd_addr_sel];
   end

   // result
   always_comb begin
      case (op_ff)
         plq_pkg::OP_POP, plq_pkg::OP_REMOVE, plq_pkg::OP_READ,
         plq_pkg::OP_PEEK, plq_pkg::OP_NEXT: has_value = 1'b1;
         default:                           has_value = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.value_out  <= (has_value && (status_ff == plq_pkg::ST_OK)) ? val_rd_ff : '0;
         rsp_ff.handle_out <= ((op_ff == plq_pkg::OP_PUSH) && (status_ff == plq_pkg::ST_OK))
                              ? rd_addr_ff : '0;
         rsp_ff.occupancy  <= count_ff;
         rsp_ff.status     <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== hdl/pooled_linked_queue.sv =====
// ----------------------------------------------------------------------------
// pooled_linked_queue
// FIFO of values in a fixed node pool with prev/next links and a free list.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item goes through exec and done; a push, pop or
//   remove that succeeds also goes through link (second next-link store write).
// No new item is taken before the last one is through; link exists because
//   each node store has a single write port.
// Reset: synchronous; list empty, whole pool free, no clearing pass needed.
// ----------------------------------------------------------------------------
module pooled_linked_queue (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plq_pkg::req_item_type req_item,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plq_pkg::rsp_item_type rsp_item
);

   // Controller sequence per item:
   //   accept : request latched, value/next/prev of the target node read
   //            (target is free head, list head, cursor or the given handle)
   //   exec   : checks, pointer updates, first round of store writes
   //   link   : push appends to the old tail, unlink returns the node to
   //            the free list (second write to the next-link store)
   //   done   : result moves to the output register; the next item can be
   //            accepted in the same cycle, so a waiting result does not
   //            hold up the input side once the output register drains.

   plq_pkg::ctl_cmd_type cmd;
   plq_pkg::dp_stat_type stat;

   plq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Next links come up as index + 1 through per-entry written bits; the
   // value and prev stores have none, so only written entries read back known values.
   plq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== dv/plq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_checker
// Watches both channels of the pooled linked queue, keeps its own copy of
// the node pool, links and pointers, and compares every result item in order.
// ----------------------------------------------------------------------------
module plq_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  plq_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  plq_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending
);
   import plq_pkg::*;

   localparam int PRINT_CAP = 25;

   // mirror of the pool
   logic [DATA_WIDTH-1:0] node_val [POOL_DEPTH];
   logic [LINK_W-1:0]     fwd_link [POOL_DEPTH];
   logic [LINK_W-1:0]     back_link [POOL_DEPTH];
   bit                    on_list [POOL_DEPTH];
   logic [LINK_W-1:0]     free_top, head, tail, walk;
   logic [COUNT_W-1:0]    fill;

   rsp_item_type expected_q[$];
   int           errs = 0;

   function automatic bit in_pool(logic [LINK_W-1:0] h);
      return h < POOL_DEPTH;
   endfunction

   task automatic clear_pool();
      for (int i = 0; i < POOL_DEPTH; i++) begin
         node_val[i]  = '0;
         fwd_link[i]  = LINK_W'(i + 1);
         back_link[i] = NIL;
         on_list[i]   = 1'b0;
      end
      free_top = '0;
      head     = NIL;
      tail     = NIL;
      walk     = NIL;
      fill     = '0;
   endtask

   // take a live node out of the chain and hand it back to the free list
   task automatic detach(input logic [LINK_W-1:0] h);
      logic [LINK_W-1:0] p, n;
      p = back_link[h];
      n = fwd_link[h];
      if (in_pool(p)) fwd_link[p] = n;
      else            head = n;
      if (in_pool(n)) back_link[n] = p;
      else            tail = p;
      if (walk == h) walk = n;
      on_list[h]   = 1'b0;
      fwd_link[h]  = free_top;
      back_link[h] = NIL;
      free_top     = h;
      if (fill != 0) fill--;
      if (fill == 0) begin
         head = NIL;
         tail = NIL;
      end
   endtask

   task automatic predict_result(input req_item_type rq, output rsp_item_type res);
      logic [LINK_W-1:0] n, h;
      res = '0;
      h   = {1'b0, rq.handle_in};
      case (op_type'(rq.req_type))
         OP_PUSH: begin
            if (!in_pool(free_top)) begin
               res.status = ST_FULL;
            end else begin
               n            = free_top;
               free_top     = fwd_link[n];
               node_val[n]  = rq.value_in;
               fwd_link[n]  = NIL;
               back_link[n] = tail;
               on_list[n]   = 1'b1;
               if (in_pool(tail)) fwd_link[tail] = n;
               else               head = n;
               tail = n;
               fill++;
               res.handle_out = n[HANDLE_W-1:0];
            end
         end
         OP_POP: begin
            if (fill == 0 || !in_pool(head)) begin
               res.status = ST_EMPTY;
            end else begin
               res.value_out = node_val[head];
               detach(head);
            end
         end
         OP_REMOVE: begin
            if (!in_pool(h) || !on_list[h]) begin
               res.status = ST_EMPTY;
            end else begin
               res.value_out = node_val[h];
               detach(h);
            end
         end
         OP_READ: begin
            if (in_pool(h)) res.value_out = node_val[h];
         end
         OP_WRITE: begin
            if (in_pool(h)) node_val[h] = rq.value_in;
         end
         OP_PEEK: begin
            if (fill == 0 || !in_pool(head)) res.status = ST_EMPTY;
            else                             res.value_out = node_val[head];
         end
         OP_REWIND: begin
            walk = head;
         end
         OP_NEXT: begin
            if (!in_pool(walk)) begin
               res.status = ST_END;
               walk       = NIL;
            end else begin
               res.value_out = node_val[walk];
               walk          = fwd_link[walk];
            end
         end
         default: ;
      endcase
      res.occupancy = fill;
   endtask

   task automatic report_mismatch(input string msg);
      if (errs < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errs++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want, got;
      if (reset) begin
         clear_pool();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_item;
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result item %h with nothing outstanding", got));
            end else begin
               want = expected_q.pop_front();
               if (got.value_out !== want.value_out)
                  report_mismatch($sformatf("value_out %h, expected %h",
                                            got.value_out, want.value_out));
               if (got.handle_out !== want.handle_out)
                  report_mismatch($sformatf("handle_out %0d, expected %0d",
                                            got.handle_out, want.handle_out));
               if (got.occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            got.occupancy, want.occupancy));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
            end
         end
         if (req_valid && req_ready) begin
            predict_result(req_item, want);
            expected_q.push_back(want);
         end
      end
      pending    <= expected_q.size();
      fail_count <= errs;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the pooled linked queue with a directed opening and phased random
// traffic under random idling on both channels; plq_checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
   import plq_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 8;
   localparam int RECENT_KEEP  = 64;

   // traffic mixes, cycled through one phase after another
   typedef enum int {MIX_FILL, MIX_WALK, MIX_DRAIN, MIX_BLEND} mix_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   int fail_count;
   int pending;
   int cycles = 0;

   // Stimulus bookkeeping. A read may only target a node known to hold a
   // value: one that was written, or one a push has been seen to allocate.
   bit                  written_map [POOL_DEPTH];
   logic [HANDLE_W-1:0] written_list[$];
   logic [HANDLE_W-1:0] recent_pushes[$];
   op_type              issued_ops[$];

   bit calm_req = 1'b0;
   bit calm_rsp = 1'b0;
   int sent     = 0;
   int results  = 0;
   int full_hits  = 0;
   int empty_hits = 0;
   int end_hits   = 0;

   pooled_linked_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   plq_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hang or a lost result item ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("tb failed");
         $finish;
      end
   end

   task automatic note_written(input logic [HANDLE_W-1:0] h);
      if (!written_map[h]) begin
         written_map[h] = 1'b1;
         written_list.push_back(h);
      end
   endtask

   // Present one item from a falling edge and hold it until accepted. With a
   // zero gap valid simply stays high and only the payload moves on.
   task automatic send_op(input op_type op, input logic [DATA_WIDTH-1:0] val,
                          input logic [HANDLE_W-1:0] h);
      req_item_type it;
      int           gap;
      it.req_type  = op;
      it.value_in  = val;
      it.handle_in = h;
      if (op == OP_WRITE) note_written(h);
      gap = calm_req ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued_ops.push_back(op);
      sent++;
      @(negedge clock);
   endtask

   function automatic op_type pick_op(input mix_type m);
      int unsigned w[8];
      int unsigned roll, acc;
      // order: push pop remove read write peek rewind next
      case (m)
         MIX_FILL:  w = '{65,  6,  6,  6, 6, 4,  3,  4};
         MIX_WALK:  w = '{22,  8, 14,  8, 5, 5, 12, 26};
         MIX_DRAIN: w = '{14, 36, 22,  8, 6, 6,  3,  5};
         default:   w = '{30, 20, 12, 10, 8, 6,  5,  9};
      endcase
      roll = $urandom_range(0, 99);
      acc  = 0;
      for (int i = 0; i < 8; i++) begin
         acc += w[i];
         if (roll < acc) return op_type'(i);
      end
      return OP_PEEK;
   endfunction

   task automatic random_item(input mix_type m);
      op_type              op;
      logic [DATA_WIDTH-1:0] val;
      logic [HANDLE_W-1:0] h;
      int unsigned         pick;
      op   = pick_op(m);
      pick = $urandom_range(0, 9);
      val  = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
      h    = HANDLE_W'($urandom_range(0, POOL_DEPTH - 1));
      case (op)
         // mostly aim at nodes that were recently pushed, so that live ones,
         // the tail and the cursor node get hit; the rest use any handle, live or dead
         OP_REMOVE: begin
            if (recent_pushes.size() != 0 && $urandom_range(0, 99) < 70)
               h = recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
         end
         OP_READ: begin
            if (written_list.size() == 0) op = OP_PEEK;
            else h = written_list[$urandom_range(0, written_list.size() - 1)];
         end
         default: ;
      endcase
      send_op(op, val, h);
   endtask

   // result side: random stalls, and harvest of allocated handles
   initial begin
      op_type op;
      int     stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = calm_rsp ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         results++;
         if (rsp_item.status == ST_FULL)  full_hits++;
         if (rsp_item.status == ST_EMPTY) empty_hits++;
         if (rsp_item.status == ST_END)   end_hits++;
         if (issued_ops.size() != 0) begin
            op = issued_ops.pop_front();
            if (op == OP_PUSH && rsp_item.status == ST_OK) begin
               note_written(rsp_item.handle_out);
               recent_pushes.push_back(rsp_item.handle_out);
               if (recent_pushes.size() > RECENT_KEEP) void'(recent_pushes.pop_front());
            end
         end
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      mix_type kind;
      int      phase_len;
      int      done_items;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed opening. After reset the free list runs 0, 1, 2 ... so the
      // first pushes land on handles 0 to 3.
      send_op(OP_POP,    '0, '0);              // empty queue
      send_op(OP_PEEK,   '0, '1);              // empty queue
      send_op(OP_NEXT,   '0, '0);              // cursor never set
      send_op(OP_REWIND, '0, '0);              // rewind on empty queue
      send_op(OP_REMOVE, '0, 7'd5);            // handle not live
      send_op(OP_PUSH,   32'h0000_0000, '0);
      send_op(OP_PUSH,   32'hFFFF_FFFF, '1);
      send_op(OP_PUSH,   32'hA5A5_A5A5, '0);
      send_op(OP_PUSH,   32'h5A5A_5A5A, '0);
      send_op(OP_PEEK,   '0, '0);
      send_op(OP_REWIND, '0, '0);              // cursor on handle 0
      send_op(OP_NEXT,   '0, '0);              // cursor moves to handle 1
      send_op(OP_REMOVE, '0, 7'd1);            // node under the cursor
      send_op(OP_NEXT,   '0, '0);              // cursor had moved to handle 2
      send_op(OP_REMOVE, '0, 7'd3);            // tail removed, cursor falls off
      send_op(OP_NEXT,   '0, '0);              // cursor at end
      send_op(OP_WRITE,  32'hFFFF_FFFF, '1);   // free node
      send_op(OP_READ,   '0, '1);
      send_op(OP_READ,   '0, 7'd1);            // freed node keeps its value
      send_op(OP_WRITE,  32'h1234_5678, '0);   // live head
      send_op(OP_POP,    '0, '0);
      send_op(OP_POP,    '0, '0);              // queue empties, tail goes null
      send_op(OP_POP,    '0, '0);
      send_op(OP_PUSH,   32'h8000_0001, '0);
      send_op(OP_REMOVE, '0, '1);              // free node, refused

      // Phased random traffic: a fill phase long enough to hit a full pool,
      // cursor walks, a drain back towards empty, then a blend.
      kind       = MIX_FILL;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         phase_len = (kind == MIX_FILL || kind == MIX_DRAIN) ? 320 : $urandom_range(120, 220);
         calm_req  = ($urandom_range(0, 3) == 0);
         calm_rsp  = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < phase_len && done_items < RANDOM_ITEMS; k++) begin
            random_item(kind);
            done_items++;
         end
         kind = mix_type'((int'(kind) + 1) % 4);
      end
      req_valid <= 1'b0;

      // drain every outstanding result item, then watch for strays
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d requests sent, %0d results received in %0d cycles", sent, results, cycles);
      $display("refusals seen: %0d pool full, %0d empty or dead handle, %0d cursor at end",
               full_hits, empty_hits, end_hits);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
